/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, sampled on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* design/efg_pkg.sv */
// ----------------------------------------------------------------------------
// efg_pkg
// types, codes and helpers shared by the event flag group modules
// ----------------------------------------------------------------------------
package efg_pkg;

  localparam int NUM_WAITERS = 16;
  localparam int FLAG_BITS   = 32;
  localparam int SLOT_W      = $clog2(NUM_WAITERS);
  localparam int CNT_W       = $clog2(NUM_WAITERS + 1);

  // operation codes
  localparam logic [1:0] KIND_POST   = 2'd0;
  localparam logic [1:0] KIND_CLEAR  = 2'd1;
  localparam logic [1:0] KIND_WAIT   = 2'd2;
  localparam logic [1:0] KIND_CANCEL = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_INVALID     = 3'd1;
  localparam logic [2:0] ST_WOULD_BLOCK = 3'd2;
  localparam logic [2:0] ST_BLOCKED     = 3'd3;
  localparam logic [2:0] ST_TIMED_OUT   = 3'd4;
  localparam logic [2:0] ST_WOKEN       = 3'd5;

  typedef struct packed {
    logic [2:0]           status;
    logic [SLOT_W-1:0]    waiter;
    logic [FLAG_BITS-1:0] flags;
    logic                 last;
  } result_t;

  // one waiter table entry
  typedef struct packed {
    logic                 all_mode;
    logic [FLAG_BITS-1:0] mask;
  } slot_t;

  function automatic logic cond_holds(logic [FLAG_BITS-1:0] word,
                                      logic [FLAG_BITS-1:0] mask,
                                      logic                 all_mode);
    logic [FLAG_BITS-1:0] hit;
    hit = word & mask;
    if (all_mode) begin
      return hit == mask;
    end
    return hit != '0;
  endfunction

endpackage

/* design/event_flag_group_waiters.sv */
// ----------------------------------------------------------------------------
// event_flag_group_waiters: event flag word with a table of blocked waiters
// clear and wait go straight to the result; cancel walks the queue through the order
// memory; post walks it oldest first, paced by the read of the order memory then the
// slot memory for each queued waiter, and emits each woken waiter; one item at a time
// reset clears flags, waiting bits and count at once; no clearing pass
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module event_flag_group_waiters (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] flags_i,
  input  logic        match_all_i,
  input  logic [3:0]  waiter_id_i,
  input  logic        no_wait_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [3:0]  result_waiter_o,
  output logic [31:0] flags_now_o,
  output logic        last_o
);

  localparam int SLOT_W = efg_pkg::SLOT_W;
  localparam int CNT_W  = efg_pkg::CNT_W;
  localparam int FB     = efg_pkg::FLAG_BITS;
  localparam int NW     = efg_pkg::NUM_WAITERS;

  // sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_RD_ORD  = 3'd2;
  localparam logic [2:0] S_RD_SLOT = 3'd3;
  localparam logic [2:0] S_EMIT    = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [FB-1:0]    ew_q, ew_d;          // event flag word
  logic [NW-1:0]    waiting_q, waiting_d;
  logic [CNT_W-1:0] count_q, count_d;    // queued waiters
  logic [CNT_W-1:0] idx_q, idx_d;        // scan read position
  logic [CNT_W-1:0] kept_q, kept_d;      // compaction write position
  logic             cancel_q, cancel_d;  // scan removes one slot instead of waking
  logic [SLOT_W-1:0] id_q, id_d;
  efg_pkg::result_t res_q, res_d;        // result waiting for the output register

  // waiter table: per-slot mask and mode, and the arrival queue of slot numbers
  efg_pkg::slot_t    slot_mem [NW];
  logic [SLOT_W-1:0] ord_mem  [NW];
  efg_pkg::slot_t    slot_rd_q;
  logic [SLOT_W-1:0] ord_rd_q;

  logic              slot_we;
  logic [SLOT_W-1:0] slot_waddr;
  efg_pkg::slot_t    slot_wdata;
  logic              ord_we;
  logic [SLOT_W-1:0] ord_waddr;
  logic [SLOT_W-1:0] ord_wdata;

  logic             push_valid;
  logic             push_ready;
  efg_pkg::result_t out_data;
  logic             accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign push_valid = (state_q == S_EMIT);

  always_comb begin
    state_d    = state_q;
    ew_d       = ew_q;
    waiting_d  = waiting_q;
    count_d    = count_q;
    idx_d      = idx_q;
    kept_d     = kept_q;
    cancel_d   = cancel_q;
    id_d       = id_q;
    res_d      = res_q;
    slot_we    = 1'b0;
    slot_waddr = waiter_id_i;
    slot_wdata = '{all_mode: match_all_i, mask: flags_i};
    ord_we     = 1'b0;
    ord_waddr  = kept_q[SLOT_W-1:0];
    ord_wdata  = ord_rd_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          id_d    = waiter_id_i;
          idx_d   = '0;
          kept_d  = '0;
          state_d = S_EMIT;
          case (kind_i)
            efg_pkg::KIND_POST: begin
              // or in the bits, then walk the queue oldest first
              ew_d     = ew_q | flags_i;
              cancel_d = 1'b0;
              state_d  = S_SCAN;
            end
            efg_pkg::KIND_CLEAR: begin
              ew_d  = ew_q & ~flags_i;
              res_d = '{status: efg_pkg::ST_OK, waiter: '0, flags: ew_d, last: 1'b1};
            end
            efg_pkg::KIND_WAIT: begin
              res_d = '{status: efg_pkg::ST_INVALID, waiter: waiter_id_i, flags: ew_q,
                        last: 1'b1};
              if (flags_i == '0) begin
                res_d.status = efg_pkg::ST_INVALID;
              end else if (efg_pkg::cond_holds(ew_q, flags_i, match_all_i)) begin
                res_d.status = efg_pkg::ST_OK;
              end else if (no_wait_i) begin
                res_d.status = efg_pkg::ST_WOULD_BLOCK;
              end else if (waiting_q[waiter_id_i] || count_q >= CNT_W'(NW)) begin
                res_d.status = efg_pkg::ST_INVALID;
              end else begin
                // append to the table
                slot_we                = 1'b1;
                ord_we                 = 1'b1;
                ord_waddr              = count_q[SLOT_W-1:0];
                ord_wdata              = waiter_id_i;
                waiting_d[waiter_id_i] = 1'b1;
                count_d                = count_q + CNT_W'(1);
                res_d.status           = efg_pkg::ST_BLOCKED;
              end
            end
            default: begin
              // cancel on timeout
              if (!waiting_q[waiter_id_i]) begin
                res_d = '{status: efg_pkg::ST_INVALID, waiter: waiter_id_i, flags: ew_q,
                          last: 1'b1};
              end else begin
                waiting_d[waiter_id_i] = 1'b0;
                cancel_d               = 1'b1;
                state_d                = S_SCAN;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        if (idx_q == count_q) begin
          // queue walked: commit compacted length and close the transaction
          count_d = kept_q;
          if (cancel_q) begin
            res_d = '{status: efg_pkg::ST_TIMED_OUT, waiter: id_q, flags: ew_q,
                      last: 1'b1};
          end else begin
            res_d = '{status: efg_pkg::ST_OK, waiter: '0, flags: ew_q, last: 1'b1};
          end
          state_d = S_EMIT;
        end else begin
          state_d = S_RD_ORD;
        end
      end

      S_RD_ORD: begin
        // ord_rd_q holds the slot at the scan position
        if (cancel_q) begin
          if (ord_rd_q != id_q) begin
            ord_we = 1'b1;
            kept_d = kept_q + CNT_W'(1);
          end
          idx_d   = idx_q + CNT_W'(1);
          state_d = S_SCAN;
        end else begin
          state_d = S_RD_SLOT;
        end
      end

      S_RD_SLOT: begin
        idx_d = idx_q + CNT_W'(1);
        if (efg_pkg::cond_holds(ew_q, slot_rd_q.mask, slot_rd_q.all_mode)) begin
          waiting_d[ord_rd_q] = 1'b0;
          res_d = '{status: efg_pkg::ST_WOKEN, waiter: ord_rd_q, flags: ew_q, last: 1'b0};
          state_d = S_EMIT;
        end else begin
          // still blocked: keep it in order
          ord_we  = 1'b1;
          kept_d  = kept_q + CNT_W'(1);
          state_d = S_SCAN;
        end
      end

      S_EMIT: begin
        if (push_ready) begin
          state_d = res_q.last ? S_IDLE : S_SCAN;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ew_q      <= '0;
      waiting_q <= '0;
      count_q   <= '0;
      idx_q     <= '0;
      kept_q    <= '0;
      cancel_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      ew_q      <= ew_d;
      waiting_q <= waiting_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      kept_q    <= kept_d;
      cancel_q  <= cancel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    res_q <= res_d;
  end

  // synchronous memories with registered read data; the write position never
  // passes the next read position, so no forwarding is needed
  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    ord_rd_q  <= ord_mem[idx_q[SLOT_W-1:0]];
    slot_rd_q <= slot_mem[ord_rd_q];
  end

  efg_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (res_q),
    .push_ready_o (push_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data)
  );

  assign status_o        = out_data.status;
  assign result_waiter_o = out_data.waiter;
  assign flags_now_o     = out_data.flags;
  assign last_o          = out_data.last;

  // queue length and waiting bits agree whenever no scan is under way
  `ASSERT_IMPLIES(a_count_matches, state_q == S_IDLE,
    $countones(waiting_q) == int'(count_q), "waiter count out of step with waiting bits")
  // table never overflows
  `ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(NW), "waiter count above table size")
  // compaction never writes ahead of the scan
  `ASSERT_ALWAYS(a_kept_behind, kept_q <= idx_q, "compaction write passed scan position")

endmodule

/* design/efg_out_reg.sv */
// ----------------------------------------------------------------------------
// efg_out_reg
// output register that holds one result transaction until taken
// ----------------------------------------------------------------------------
module efg_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  efg_pkg::result_t  push_data_i,
  output logic              push_ready_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output efg_pkg::result_t  out_data_o
);

  logic             valid_q;
  efg_pkg::result_t data_q;

  // free when empty or when the held transaction leaves this cycle
  assign push_ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_ready_o) begin
      valid_q <= push_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ready_o && push_valid_i) begin
      data_q <= push_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

/* dv/efg_checker.sv */
// ----------------------------------------------------------------------------
// efg_checker
// watches both channels of the event flag group, keeps its own copy of the
// flag word and waiter table, and compares every result transaction
// ----------------------------------------------------------------------------
module efg_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  kind_i,
  input  logic [31:0] flags_i,
  input  logic        match_all_i,
  input  logic [3:0]  waiter_id_i,
  input  logic        no_wait_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  status_i,
  input  logic [3:0]  result_waiter_i,
  input  logic [31:0] flags_now_i,
  input  logic        last_i,
  output int          owed_o,
  output int          fail_o
);

  logic [31:0]                     flag_word;
  logic [efg_pkg::NUM_WAITERS-1:0] slot_busy;
  logic [31:0]                     slot_mask [efg_pkg::NUM_WAITERS];
  logic                            slot_all  [efg_pkg::NUM_WAITERS];
  logic [3:0]                      arrival_q[$];
  efg_pkg::result_t                owed_results[$];
  int                              fail_count;

  function automatic logic satisfied(logic [31:0] word, logic [31:0] mask, logic all_bits);
    if (all_bits) begin
      return (word & mask) == mask;
    end
    return (word & mask) != 32'd0;
  endfunction

  // flags_now always carries the flag word as it stands after the call
  task automatic owe(input logic [2:0] st, input logic [3:0] slot, input logic fin);
    efg_pkg::result_t r;
    r.status = st;
    r.waiter = slot;
    r.flags  = flag_word;
    r.last   = fin;
    owed_results.push_back(r);
  endtask

  task automatic track_flag_call(input logic [1:0] k, input logic [31:0] f,
                                 input logic all_bits, input logic [3:0] id,
                                 input logic nw);
    logic [3:0] kept_q[$];
    case (k)
      efg_pkg::KIND_POST: begin
        flag_word |= f;
        // wake in arrival order, survivors keep their order
        foreach (arrival_q[i]) begin
          if (satisfied(flag_word, slot_mask[arrival_q[i]], slot_all[arrival_q[i]])) begin
            slot_busy[arrival_q[i]] = 1'b0;
            owe(efg_pkg::ST_WOKEN, arrival_q[i], 1'b0);
          end else begin
            kept_q.push_back(arrival_q[i]);
          end
        end
        arrival_q = kept_q;
        owe(efg_pkg::ST_OK, 4'd0, 1'b1);
      end
      efg_pkg::KIND_CLEAR: begin
        flag_word &= ~f;
        owe(efg_pkg::ST_OK, 4'd0, 1'b1);
      end
      efg_pkg::KIND_WAIT: begin
        if (f == 32'd0) begin
          owe(efg_pkg::ST_INVALID, id, 1'b1);
        end else if (satisfied(flag_word, f, all_bits)) begin
          owe(efg_pkg::ST_OK, id, 1'b1);
        end else if (nw) begin
          owe(efg_pkg::ST_WOULD_BLOCK, id, 1'b1);
        end else if (slot_busy[id] || arrival_q.size() >= efg_pkg::NUM_WAITERS) begin
          owe(efg_pkg::ST_INVALID, id, 1'b1);
        end else begin
          slot_busy[id] = 1'b1;
          slot_mask[id] = f;
          slot_all[id]  = all_bits;
          arrival_q.push_back(id);
          owe(efg_pkg::ST_BLOCKED, id, 1'b1);
        end
      end
      default: begin
        if (!slot_busy[id]) begin
          owe(efg_pkg::ST_INVALID, id, 1'b1);
        end else begin
          slot_busy[id] = 1'b0;
          foreach (arrival_q[i]) begin
            if (arrival_q[i] != id) begin
              kept_q.push_back(arrival_q[i]);
            end
          end
          arrival_q = kept_q;
          owe(efg_pkg::ST_TIMED_OUT, id, 1'b1);
        end
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    efg_pkg::result_t want;
    if (!rst_ni) begin
      flag_word  = '0;
      slot_busy  = '0;
      fail_count = 0;
      arrival_q.delete();
      owed_results.delete();
      owed_o <= 0;
      fail_o <= 0;
    end else begin
      // a result never belongs to the call accepted at the same edge
      if (out_valid_i && !out_stall_i) begin
        if (owed_results.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, got status %0d waiter %0d",
                   $time, status_i, result_waiter_i);
        end else begin
          want = owed_results.pop_front();
          compare_field("status", 32'(want.status), 32'(status_i));
          compare_field("result_waiter", 32'(want.waiter), 32'(result_waiter_i));
          compare_field("flags_now", want.flags, flags_now_i);
          compare_field("last", 32'(want.last), 32'(last_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        track_flag_call(kind_i, flags_i, match_all_i, waiter_id_i, no_wait_i);
      end
      owed_o <= owed_results.size();
      fail_o <= fail_count;
    end
  end

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// drives kernel calls into the event flag group (post, clear, wait, cancel)
// with random idle bursts on both sides, and reports the checker's verdict
// ----------------------------------------------------------------------------
module testbench;

  localparam int RANDOM_CALLS = 155;
  localparam int CALM_FROM    = 130;     // no idling from this call on
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  kind;
  logic [31:0] flags;
  logic        match_all;
  logic [3:0]  waiter_id;
  logic        no_wait;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic [3:0]  result_waiter;
  logic [31:0] flags_now;
  logic        last;

  int owed;
  int fails;
  int cycle_count;
  bit calm;           // final stretch, both sides stop idling
  bit long_hold_req;  // asks the receiver for one long hold-off

  event_flag_group_waiters uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .kind_i          (kind),
    .flags_i         (flags),
    .match_all_i     (match_all),
    .waiter_id_i     (waiter_id),
    .no_wait_i       (no_wait),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (status),
    .result_waiter_o (result_waiter),
    .flags_now_o     (flags_now),
    .last_o          (last)
  );

  efg_checker u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .kind_i          (kind),
    .flags_i         (flags),
    .match_all_i     (match_all),
    .waiter_id_i     (waiter_id),
    .no_wait_i       (no_wait),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .status_i        (status),
    .result_waiter_i (result_waiter),
    .flags_now_i     (flags_now),
    .last_i          (last),
    .owed_o          (owed),
    .fail_o          (fails)
  );

  // clock, period 10
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // watchdog, ends a hung run
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL event_flag_group_waiters");
    $finish;
  end

  // receiver side: random stall bursts, quiet stretches, one long hold-off
  initial begin : receiver
    int hold_left;
    int quiet_left;
    bit long_done;
    hold_left  = 0;
    quiet_left = 0;
    long_done  = 1'b0;
    out_stall <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !long_done) begin
        // the block fills up behind this and stalls its input
        long_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (calm || quiet_left > 0) begin
        if (quiet_left > 0) quiet_left--;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 39) == 0) begin
        quiet_left = $urandom_range(20, 60);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(1, 13) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // sparse bit patterns, so waits often block and posts wake only some
  function automatic logic [31:0] pick_bits();
    case ($urandom_range(0, 3))
      0:       return 32'h1 << $urandom_range(0, 7);
      1:       return (32'h1 << $urandom_range(0, 7)) | (32'h1 << $urandom_range(0, 7));
      2:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  // one call transaction, sometimes with a random idle burst in front of it
  task automatic send_call(input logic [1:0] k, input logic [31:0] f, input logic all_bits,
                           input logic [3:0] id, input logic nw);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    kind      <= k;
    flags     <= f;
    match_all <= all_bits;
    waiter_id <= id;
    no_wait   <= nw;
    in_valid  <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // stop offering until every owed result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (owed != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [31:0] mask;
    int          pick;
    calm          = 1'b0;
    long_hold_req = 1'b0;
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    kind      <= efg_pkg::KIND_POST;
    flags     <= '0;
    match_all <= 1'b0;
    waiter_id <= '0;
    no_wait   <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty post, zero mask, would block
    send_call(efg_pkg::KIND_POST, 32'h0, 1'b0, 4'd0, 1'b0);
    send_call(efg_pkg::KIND_WAIT, 32'h0, 1'b1, 4'd7, 1'b0);
    send_call(efg_pkg::KIND_WAIT, 32'h1, 1'b0, 4'd2, 1'b1);
    // fill every slot, flag word is zero so all of them block
    for (int i = 0; i < efg_pkg::NUM_WAITERS; i++) begin
      mask = (i % 2 == 1) ? ((32'h1 << i) | (32'h1 << (31 - i))) : (32'h1 << i);
      send_call(efg_pkg::KIND_WAIT, mask, i[0], i[3:0], 1'b0);
    end
    // slot already waiting with the table full
    send_call(efg_pkg::KIND_WAIT, 32'h8, 1'b0, 4'd3, 1'b0);
    // cancel a waiter, cancel it again, then it rejoins at the tail
    send_call(efg_pkg::KIND_CANCEL, 32'h0, 1'b0, 4'd5, 1'b0);
    send_call(efg_pkg::KIND_CANCEL, 32'h0, 1'b0, 4'd5, 1'b0);
    send_call(efg_pkg::KIND_WAIT, 32'h20, 1'b0, 4'd5, 1'b0);
    // all ones wakes all sixteen waiters in one post
    send_call(efg_pkg::KIND_POST, 32'hFFFF_FFFF, 1'b0, 4'd0, 1'b0);
    // satisfied at once, then wipe the word
    send_call(efg_pkg::KIND_WAIT, 32'hFFFF_FFFF, 1'b1, 4'd9, 1'b0);
    send_call(efg_pkg::KIND_CLEAR, 32'hFFFF_FFFF, 1'b0, 4'd0, 1'b0);

    // random calls, mostly sparse masks so the waiter table stays busy
    for (int n = 0; n < RANDOM_CALLS; n++) begin
      if (n == 60) drain();
      if (n == 100) long_hold_req = 1'b1;
      calm = (n >= CALM_FROM);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_call(2'($urandom_range(0, 3)), $urandom(), 1'($urandom_range(0, 1)),
                  4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      end else if (pick < 50) begin
        send_call(efg_pkg::KIND_WAIT, pick_bits(), 1'($urandom_range(0, 1)),
                  4'($urandom_range(0, 15)), $urandom_range(0, 7) == 0);
      end else if (pick < 68) begin
        send_call(efg_pkg::KIND_POST, pick_bits(), 1'($urandom_range(0, 1)),
                  4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      end else if (pick < 80) begin
        send_call(efg_pkg::KIND_CLEAR,
                  ($urandom_range(0, 3) == 0) ? pick_bits() : $urandom(),
                  1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                  1'($urandom_range(0, 1)));
      end else begin
        send_call(efg_pkg::KIND_CANCEL, $urandom(), 1'($urandom_range(0, 1)),
                  4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      end
    end

    // wait for the last results, then a margin past the longest post
    drain();
    repeat (80) @(posedge clk_i);
    if (fails == 0) begin
      $display("PASS event_flag_group_waiters");
    end else begin
      $display("FAIL event_flag_group_waiters");
    end
    $finish;
  end

endmodule
